[rtl/core/lz78_trie_encoder_assert.svh]
// Assertion macros for the LZ78 trie encoder.
`ifndef LZ78_TRIE_ENCODER_ASSERT_SVH
`define LZ78_TRIE_ENCODER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define LZ78_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define LZ78_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/lz78_pkg.sv]
// Shared constants and types of the LZ78 trie encoder.
package lz78_pkg;

  localparam int SYMBOL_BITS = 8;
  localparam int MAX_NODES   = 1024;

  localparam int SYM_W     = 8;
  localparam int PHRASE_W  = 10;
  localparam int OUT_CODE_W = 4;

  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int ID_W      = NODE_W + 1;
  localparam int ADDR_W    = NODE_W + SYMBOL_BITS;
  localparam int MEM_DEPTH = MAX_NODES * (2 ** SYMBOL_BITS);
  localparam int CODE_W    = $clog2(NODE_W + 2);
  localparam int DIFF_W    = (SYMBOL_BITS > SYM_W) ? SYMBOL_BITS : SYM_W;

  localparam int FIRST_NODE_ID = 3;
  // bit length of FIRST_NODE_ID - 1
  localparam int FIRST_CODE_W  = $clog2(FIRST_NODE_ID);

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [NODE_W-1:0] data;
  } mem_wr_t;

  typedef struct packed {
    logic              room;
    logic [ID_W-1:0]   id;
    logic [CODE_W-1:0] code_w;
  } dict_t;

endpackage

[rtl/core/lz78_if.sv]
// Channel interfaces: symbol input, result output, symbol_min write.
interface lz78_sym_if import lz78_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             last_symbol;

  modport source (output valid, symbol, last_symbol, input ready);
  modport sink   (input valid, symbol, last_symbol, output ready);
endinterface

interface lz78_res_if import lz78_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [PHRASE_W-1:0]   phrase_node;
  logic [OUT_CODE_W-1:0] code_bits;
  logic [SYM_W-1:0]      literal;
  logic                  has_literal;

  modport source (output valid, phrase_node, code_bits, literal, has_literal,
                  input ready);
  modport sink   (input valid, phrase_node, code_bits, literal, has_literal,
                  output ready);
endinterface

interface lz78_cfg_if import lz78_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol_min;

  modport source (output valid, symbol_min, input ready);
  modport sink   (input valid, symbol_min, output ready);
endinterface

[rtl/core/lz78_child_mem.sv]
// Child table: one write port, one read port with registered read data.
module lz78_child_mem import lz78_pkg::*; (
  input  logic              clk,
  input  mem_wr_t           wr,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [NODE_W-1:0] rd_data
);

  logic [NODE_W-1:0] mem [MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // read-before-write on a collision; the caller forwards
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/lz78_dict.sv]
// Node id allocator with running code width of the highest assigned id.
module lz78_dict import lz78_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  grow,
  output dict_t dict
);

  logic [ID_W-1:0]   id;
  logic [CODE_W-1:0] code_w;
  logic              room;
  logic              id_pow2;

  assign room    = id < ID_W'(MAX_NODES);
  // after the step, id becomes the highest assigned id; its bit length
  // goes up by one exactly when it is a power of two
  assign id_pow2 = (id & (id - ID_W'(1))) == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      id     <= ID_W'(FIRST_NODE_ID);
      code_w <= CODE_W'(FIRST_CODE_W);
    end else if (grow && room) begin
      id <= id + ID_W'(1);
      if (id_pow2) begin
        code_w <= code_w + CODE_W'(1);
      end
    end
  end

  assign dict.room   = room;
  assign dict.id     = id;
  assign dict.code_w = code_w;

endmodule

[rtl/core/lz78_trie_encoder.sv]
// Top level of the LZ78 trie encoder: trie walk pipeline and output register.
//
// One symbol request per cycle is taken in sustained flow while the result
// channel is not stalled; a symbol is registered in the resolve stage and its
// result in the output register. The child table is a single-port-read,
// single-port-write RAM of MAX_NODES * 2^SYMBOL_BITS entries (262144 here);
// the table read of one symbol and the decision of the one before it share
// a cycle, with the next node forwarded from the read data and a same-entry
// write forwarded around the RAM. After reset a clearing pass writes every
// table entry once, during which no symbol is taken; symbol_min writes are
// taken at any time and apply to symbols accepted afterwards.
`include "lz78_trie_encoder_assert.svh"

module lz78_trie_encoder import lz78_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  lz78_sym_if.sink  sym,
  lz78_res_if.source res,
  lz78_cfg_if.sink  cfg
);

  logic [SYM_W-1:0]  symbol_min;
  logic              clearing;
  logic [ADDR_W-1:0] clr_addr;
  logic [NODE_W-1:0] cur_node;

  // resolve stage
  logic              s2_valid;
  logic [SYM_W-1:0]  s2_sym;
  logic              s2_last;
  logic [ADDR_W-1:0] s2_addr;
  logic              s2_hit;
  logic [NODE_W-1:0] s2_fwd;

  logic [NODE_W-1:0]      rd_data;
  logic [ADDR_W-1:0]      rd_addr;
  logic [NODE_W-1:0]      rd_node;
  logic [SYMBOL_BITS-1:0] idx;
  logic                   sym_acc;
  logic                   s2_adv;
  logic [NODE_W-1:0]      s2_node;
  logic [NODE_W-1:0]      child;
  logic                   is_match;
  logic                   need_out;
  logic [NODE_W-1:0]      s2_next_node;
  logic                   s2_wr;
  mem_wr_t                wr;
  dict_t                  dict;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_min <= '0;
    end else if (cfg.valid) begin
      symbol_min <= cfg.symbol_min;
    end
  end

  // clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + ADDR_W'(1);
      if (clr_addr == ADDR_W'(MEM_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  assign s2_node  = s2_addr[ADDR_W-1:SYMBOL_BITS];
  assign child    = s2_hit ? s2_fwd : rd_data;
  assign is_match = child != '0;
  assign need_out = !is_match || s2_last;
  assign s2_next_node = (is_match && !s2_last) ? child : '0;

  assign s2_adv  = s2_valid && (!res.valid || res.ready);
  assign sym.ready = !clearing && (!s2_valid || s2_adv);
  assign sym_acc = sym.valid && sym.ready;
  assign s2_wr   = s2_adv && !is_match && dict.room;

  assign idx     = SYMBOL_BITS'(DIFF_W'(sym.symbol) - DIFF_W'(symbol_min));
  assign rd_node = s2_adv ? s2_next_node : cur_node;
  assign rd_addr = {rd_node, idx};

  always_comb begin
    if (clearing) begin
      wr.en   = 1'b1;
      wr.addr = clr_addr;
      wr.data = '0;
    end else begin
      wr.en   = s2_wr;
      wr.addr = s2_addr;
      wr.data = dict.id[NODE_W-1:0];
    end
  end

  lz78_child_mem u_mem (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (sym_acc),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  lz78_dict u_dict (
    .clk  (clk),
    .rst  (rst),
    .grow (s2_wr),
    .dict (dict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      cur_node <= '0;
    end else begin
      s2_valid <= sym_acc || (s2_valid && !s2_adv);
      if (s2_adv) begin
        cur_node <= s2_next_node;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sym_acc) begin
      s2_sym  <= sym.symbol;
      s2_last <= sym.last_symbol;
      s2_addr <= rd_addr;
      // write landing on the entry being read this cycle
      s2_hit  <= wr.en && (wr.addr == rd_addr);
      s2_fwd  <= wr.data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else begin
      res.valid <= (s2_adv && need_out) || (res.valid && !res.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && need_out) begin
      res.phrase_node <= PHRASE_W'(is_match ? child : s2_node);
      res.code_bits   <= OUT_CODE_W'(dict.code_w);
      res.literal     <= is_match ? '0 : s2_sym;
      res.has_literal <= !is_match;
    end
  end

  `LZ78_ASSERT_NOW(a_no_walk_in_clear, clearing, !s2_valid && !res.valid, "walk active during clearing pass")
  `LZ78_ASSERT_NOW(a_node_assigned, 1'b1, ID_W'(cur_node) < dict.id, "current node beyond assigned ids")
  `LZ78_ASSERT_NEXT(a_id_step, s2_wr, dict.id == $past(dict.id) + ID_W'(1), "node id did not advance on insert")

endmodule
